>>> rtl/cpd_pkg.sv
// Shared types and constants for the closest pair distance block.
package cpd_pkg;

   localparam int IN_COORD_W = 24;
   localparam int SQ_OUT_W   = 49;
   localparam int ROOT_W     = 41;
   localparam int FRAC_BITS  = 16;

   typedef struct packed {
      logic signed [IN_COORD_W-1:0] point_x;
      logic signed [IN_COORD_W-1:0] point_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic [SQ_OUT_W-1:0] min_sq_distance;
      logic [ROOT_W-1:0]   min_distance_fixed;
      logic                too_few_points;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_stat_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_I,
      ST_LATCH_I,
      ST_RD_J,
      ST_DIFF,
      ST_MULX,
      ST_MULY,
      ST_ACC,
      ST_SQRT
   } state_type;

endpackage

>>> rtl/cpd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module cpd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cpd_sqrt.sv
// Iterative fixed-point square root, two radicand bits per cycle.
module cpd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cpd_pkg::SQ_OUT_W-1:0]   radicand,
   output cpd_pkg::sqrt_stat_type         stat
);
   import cpd_pkg::*;

   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(ROOT_W);

   logic              running_ff, running_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = '0;
         rad_in     = RAD_W'({radicand, {(2 * FRAC_BITS){1'b0}}});
         rem_in     = '0;
         root_in    = '0;
      end else if (running_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign stat.done = done_ff;
   assign stat.root = root_ff;

endmodule

>>> rtl/closest_pair_distance.sv
// Closest pair of 2-D points: point store, pairwise squared-distance search and root.
//
// Points are transferred one per cycle while busy is low (start high); each is
// written to the point store until MAX_POINTS are held, later points are dropped.
// The transfer with last_point set closes the set. With fewer than two points
// held, the result (too_few_points = 1, distances 0) comes on the next cycle and
// busy stays low. Otherwise busy rises and the search walks every pair (i, j),
// i < j, through one shared multiplier: it reads and latches point i, then for each
// pair does a store read, abs differences, dx*dx, dy*dy, and an add and compare. The
// square root then runs in the root unit. The search is paced by the store's
// single read port and the one multiplier. The result is marked by rsp_valid
// for exactly one cycle and stays on rsp_data until the next result; the receiver
// cannot stall it, and busy falls in that same cycle, so the next set can start.
module closest_pair_distance #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cpd_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output cpd_pkg::rsp_type rsp_data
);
   import cpd_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int CW1  = CW + 1;
   localparam int PW   = 2 * CW;          // one square
   localparam int SQW  = 2 * CW + 1;      // sum of two squares
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;

   logic [CNTW-1:0]     count_ff, count_in;
   logic [AW-1:0]       i_ff, i_in;
   logic [AW-1:0]       j_ff, j_in;
   logic signed [CW-1:0] pi_x_ff, pi_x_in;
   logic signed [CW-1:0] pi_y_ff, pi_y_in;
   logic [CW-1:0]       dx_ff, dx_in;
   logic [CW-1:0]       dy_ff, dy_in;
   logic [PW-1:0]       sqx_ff, sqx_in;
   logic [PW-1:0]       sqy_ff, sqy_in;
   logic [SQW-1:0]      best_ff, best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Load side
   logic                accept;
   logic                load_last;
   logic                full;
   logic [CNTW-1:0]     count_after;
   logic signed [CW-1:0] in_x, in_y;

   // Store
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic [2*CW-1:0]     rd_data;

   // Search datapath
   logic [AW-1:0]       last_idx;
   logic                row_end;
   logic                last_pair;
   logic signed [CW-1:0] pj_x, pj_y;
   logic signed [CW:0]  diff_x, diff_y;
   logic [CW:0]         mag_x, mag_y;
   logic [CW-1:0]       mul_a;
   logic [PW-1:0]       prod;
   logic [SQW-1:0]      sum;

   // Root unit
   logic                sqrt_start;
   sqrt_stat_type       sqrt_stat;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign load_last = accept && req_data.last_point;

   // Low COORD_BITS of each coordinate, sign-extended.
   assign in_x = CW'(req_data.point_x);
   assign in_y = CW'(req_data.point_y);

   assign full        = (count_ff >= CNTW'(MAX_POINTS));
   assign count_after = full ? count_ff : count_ff + CNTW'(1);
   assign wr_en       = accept && !full;

   assign rd_addr = (state_ff == ST_RD_I) ? i_ff : j_ff;

   cpd_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({in_x, in_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign last_idx  = AW'(count_ff - CNTW'(1));
   assign row_end   = (j_ff == last_idx);
   assign last_pair = row_end && ((i_ff + AW'(1)) == last_idx);

   assign pj_x = signed'(rd_data[2*CW-1:CW]);
   assign pj_y = signed'(rd_data[CW-1:0]);

   // |a - b| of two CW-bit signed values always fits CW unsigned bits.
   assign diff_x = CW1'(pi_x_ff) - CW1'(pj_x);
   assign diff_y = CW1'(pi_y_ff) - CW1'(pj_y);
   assign mag_x  = diff_x[CW] ? unsigned'(-diff_x) : unsigned'(diff_x);
   assign mag_y  = diff_y[CW] ? unsigned'(-diff_y) : unsigned'(diff_y);

   // Shared squarer: dx in MULX, dy in MULY.
   assign mul_a = (state_ff == ST_MULX) ? dx_ff : dy_ff;
   assign prod  = PW'(mul_a) * PW'(mul_a);
   assign sum   = SQW'(sqx_ff) + SQW'(sqy_ff);

   assign sqrt_start = (state_ff == ST_ACC) && last_pair;

   cpd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (SQ_OUT_W'(best_in)),
      .stat     (sqrt_stat)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_last && (count_after >= CNTW'(2))) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I:    state_in = ST_LATCH_I;
         ST_LATCH_I: state_in = ST_RD_J;
         ST_RD_J:    state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_MULX;
         ST_MULX:    state_in = ST_MULY;
         ST_MULY:    state_in = ST_ACC;
         ST_ACC: begin
            if (last_pair) begin
               state_in = ST_SQRT;
            end else if (row_end) begin
               state_in = ST_RD_I;
            end else begin
               state_in = ST_RD_J;
            end
         end
         ST_SQRT: begin
            if (sqrt_stat.done) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pi_x_in      = pi_x_ff;
      pi_y_in      = pi_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = count_after;
               if (req_data.last_point) begin
                  if (count_after < CNTW'(2)) begin
                     // Fewer than two points: flagged result, store emptied.
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in.min_sq_distance    = '0;
                     rsp_data_in.min_distance_fixed = '0;
                     rsp_data_in.too_few_points     = 1'b1;
                  end else begin
                     i_in    = '0;
                     best_in = '1;
                  end
               end
            end
         end
         ST_LATCH_I: begin
            pi_x_in = signed'(rd_data[2*CW-1:CW]);
            pi_y_in = signed'(rd_data[CW-1:0]);
            j_in    = i_ff + AW'(1);
         end
         ST_DIFF: begin
            dx_in = mag_x[CW-1:0];
            dy_in = mag_y[CW-1:0];
         end
         ST_MULX: sqx_in = prod;
         ST_MULY: sqy_in = prod;
         ST_ACC: begin
            if (sum < best_ff) begin
               best_in = sum;
            end
            if (row_end) begin
               i_in = i_ff + AW'(1);
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_SQRT: begin
            if (sqrt_stat.done) begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in.min_sq_distance    = SQ_OUT_W'(best_ff);
               rsp_data_in.min_distance_fixed = sqrt_stat.root;
               rsp_data_in.too_few_points     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      pi_x_ff     <= pi_x_in;
      pi_y_ff     <= pi_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result only follows a finished root or a closing transfer of a tiny set.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_SQRT) || $past(load_last))
      else $error("result strobe without a finished search or short set");

   // A short-set result carries zero distances.
   a_too_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.too_few_points) |->
         (rsp_data.min_sq_distance == '0) && (rsp_data.min_distance_fixed == '0))
      else $error("short-set result with nonzero distance");

   // Store fill never runs past its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_POINTS))
      else $error("point count beyond store depth");

   // The search only runs with at least two points held.
   a_search_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_I) |-> (count_ff >= CNTW'(2)))
      else $error("pair search started with fewer than two points");

endmodule
